// ===== hw/rtl/lir_pkg.sv =====
// Shared types and constants of the linear interpolation resampler.
package lir_pkg;

  localparam int SAMPLE_BITS   = 24;
  localparam int FRAC_BITS     = 16;
  localparam int MAX_CHANNELS  = 2;
  localparam int MAX_RESULTS   = 64;
  localparam int INDEX_BITS    = 32;
  localparam int POS_BITS      = INDEX_BITS + FRAC_BITS;
  localparam int STEP_BITS     = 23;
  localparam int CHAN_BITS     = 2;
  localparam int COUNT_BITS    = $clog2(MAX_RESULTS) + 1;
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 32;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_CHANNEL_COUNT = 2'd0,
    REG_POSITION_STEP = 2'd1,
    REG_OUTPUT_FRAMES = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample_a;
    logic signed [SAMPLE_BITS-1:0] sample_b;
    logic                          last_frame;
  } in_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] out_a;
    logic signed [SAMPLE_BITS-1:0] out_b;
    logic                          run_last;
    logic                          stream_done;
  } out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_MUL,
    ST_ADD,
    ST_LOAD
  } ctrl_state_e;

  typedef struct packed {
    logic capture;
    logic eval;
    logic mul;
    logic add;
    logic load;
    logic finish;
  } ctl_cmd_t;

  typedef struct packed {
    logic more;
    logic out_free;
  } dp_status_t;

endpackage

// ===== hw/rtl/lir_ctrl.sv =====
// Control state machine of the linear interpolation resampler.
module lir_ctrl import lir_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  dp_status_t status_i,
  input  logic       more_q_i,
  output ctl_cmd_t   cmd_o
);

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_EVAL;
        end
      end
      ST_EVAL: begin
        cmd_o.eval = 1'b1;
        if (status_i.more) begin
          state_d = ST_MUL;
        end else begin
          cmd_o.finish = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      ST_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = ST_ADD;
      end
      ST_ADD: begin
        cmd_o.add  = 1'b1;
        cmd_o.eval = 1'b1;
        state_d    = ST_LOAD;
      end
      ST_LOAD: begin
        if (status_i.out_free) begin
          cmd_o.load = 1'b1;
          if (more_q_i) begin
            state_d = ST_MUL;
          end else begin
            cmd_o.finish = 1'b1;
            state_d      = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== hw/rtl/lir_datapath.sv =====
// Datapath of the linear interpolation resampler: registers, positions and interpolation.
module lir_datapath import lir_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [CFG_IDX_BITS-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_BITS-1:0] cfg_data_i,
  input  in_t                      in_data_i,
  output out_t                     out_data_o,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  input  ctl_cmd_t                 cmd_i,
  output dp_status_t               status_o,
  output logic                     more_q_o
);

  localparam int  PROD_BITS  = SAMPLE_BITS + FRAC_BITS + 1;
  localparam int  SUM_BITS   = PROD_BITS + 1;
  localparam bit  HAS_STEREO = (MAX_CHANNELS >= 2);
  localparam logic [FRAC_BITS:0]   ONE_POS = {1'b1, {FRAC_BITS{1'b0}}};
  localparam logic [SUM_BITS-1:0]  HALF    = SUM_BITS'(1) << (FRAC_BITS - 1);

  function automatic logic [SAMPLE_BITS-1:0] flip_sign(input logic [SAMPLE_BITS-1:0] v);
    flip_sign = {~v[SAMPLE_BITS-1], v[SAMPLE_BITS-2:0]};
  endfunction

  // configuration
  logic [CHAN_BITS-1:0]  chan_cnt_q;
  logic [STEP_BITS-1:0]  step_q;
  logic [INDEX_BITS-1:0] out_frames_q;

  // stream state
  logic [SAMPLE_BITS-1:0] prev_a_q, prev_b_q;
  logic                   have_prev_q;
  logic [INDEX_BITS-1:0]  frame_idx_q;
  logic [POS_BITS-1:0]    pos_q;
  logic [INDEX_BITS-1:0]  emitted_q;

  // per-request control
  logic [COUNT_BITS-1:0] n_q;
  logic                  phase_q, more_q, done_q;

  // per-request payload
  logic [SAMPLE_BITS-1:0] cur_a_q, cur_b_q;
  logic                   last_q, stereo_q;
  logic [PROD_BITS-1:0]   prod_pa_q, prod_ca_q, prod_pb_q, prod_cb_q;
  logic [SAMPLE_BITS-1:0] res_a_q, res_b_q;
  out_t                   out_q;
  logic                   out_valid_q;

  logic                   stereo;
  logic                   below_total, room, interp_ok, tail_ok, cand, next_interp, more;
  logic [FRAC_BITS-1:0]   weight_c;
  logic [FRAC_BITS:0]     weight_p;
  logic [SAMPLE_BITS-1:0] op_pa, op_pb, op_ca, op_cb;
  logic [SUM_BITS-1:0]    sum_a, sum_b;

  assign stereo = chan_cnt_q[1] && HAS_STEREO;

  assign below_total = (emitted_q < out_frames_q);
  assign room        = ~n_q[COUNT_BITS-1];
  assign interp_ok   = (pos_q[POS_BITS-1:FRAC_BITS] < frame_idx_q) && below_total && room;
  assign tail_ok     = last_q && below_total && room;
  assign cand        = phase_q;
  assign next_interp = cand && interp_ok;
  assign more        = next_interp || tail_ok;

  assign weight_c = phase_q ? pos_q[FRAC_BITS-1:0] : '0;
  assign weight_p = ONE_POS - {1'b0, weight_c};
  assign op_pa    = flip_sign(phase_q ? prev_a_q : cur_a_q);
  assign op_pb    = flip_sign(phase_q ? prev_b_q : cur_b_q);
  assign op_ca    = flip_sign(cur_a_q);
  assign op_cb    = flip_sign(cur_b_q);

  assign sum_a = SUM_BITS'(prod_pa_q) + SUM_BITS'(prod_ca_q) + HALF;
  assign sum_b = SUM_BITS'(prod_pb_q) + SUM_BITS'(prod_cb_q) + HALF;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chan_cnt_q   <= CHAN_BITS'(2);
      step_q       <= STEP_BITS'(ONE_POS);
      out_frames_q <= INDEX_BITS'(1);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_CHANNEL_COUNT: chan_cnt_q   <= cfg_data_i[CHAN_BITS-1:0];
        REG_POSITION_STEP: step_q       <= cfg_data_i[STEP_BITS-1:0];
        REG_OUTPUT_FRAMES: out_frames_q <= cfg_data_i[INDEX_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_a_q    <= '0;
      prev_b_q    <= '0;
      have_prev_q <= 1'b0;
      frame_idx_q <= '0;
      pos_q       <= '0;
      emitted_q   <= '0;
      n_q         <= '0;
      phase_q     <= 1'b0;
      more_q      <= 1'b0;
      done_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.capture) begin
        n_q     <= '0;
        phase_q <= have_prev_q;
      end
      if (cmd_i.eval) begin
        phase_q <= next_interp;
        more_q  <= more;
        done_q  <= (emitted_q == out_frames_q) || (last_q && !more);
      end
      if (cmd_i.mul) begin
        pos_q     <= pos_q + POS_BITS'(step_q);
        emitted_q <= emitted_q + INDEX_BITS'(1);
        n_q       <= n_q + COUNT_BITS'(1);
      end
      if (cmd_i.load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (cmd_i.finish) begin
        if (last_q) begin
          prev_a_q    <= '0;
          prev_b_q    <= '0;
          have_prev_q <= 1'b0;
          frame_idx_q <= '0;
          pos_q       <= '0;
          emitted_q   <= '0;
        end else begin
          prev_a_q    <= cur_a_q;
          prev_b_q    <= cur_b_q;
          have_prev_q <= 1'b1;
          frame_idx_q <= frame_idx_q + INDEX_BITS'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      cur_a_q  <= in_data_i.sample_a;
      cur_b_q  <= stereo ? in_data_i.sample_b : '0;
      last_q   <= in_data_i.last_frame;
      stereo_q <= stereo;
    end
    if (cmd_i.mul) begin
      prod_pa_q <= PROD_BITS'(op_pa) * PROD_BITS'(weight_p);
      prod_ca_q <= PROD_BITS'(op_ca) * PROD_BITS'(weight_c);
      prod_pb_q <= PROD_BITS'(op_pb) * PROD_BITS'(weight_p);
      prod_cb_q <= PROD_BITS'(op_cb) * PROD_BITS'(weight_c);
    end
    if (cmd_i.add) begin
      res_a_q <= flip_sign(sum_a[FRAC_BITS +: SAMPLE_BITS]);
      res_b_q <= stereo_q ? flip_sign(sum_b[FRAC_BITS +: SAMPLE_BITS]) : '0;
    end
    if (cmd_i.load) begin
      out_q.out_a       <= res_a_q;
      out_q.out_b       <= res_b_q;
      out_q.run_last    <= ~more_q;
      out_q.stream_done <= done_q;
    end
  end

  assign out_data_o        = out_q;
  assign out_valid_o       = out_valid_q;
  assign status_o.more     = more;
  assign status_o.out_free = ~out_valid_q | ~out_stall_i;
  assign more_q_o          = more_q;

endmodule

// ===== hw/rtl/linear_interp_resampler_top.sv =====
// Top level of the linear interpolation resampler.
//
//   channel   direction  handshake               payload
//   in        request    in_valid_i / in_stall_o   in_data_i (in_t)
//   out       result     out_valid_o / out_stall_i out_data_o (out_t)
//   cfg       write      cfg_we_i                  cfg_idx_i, cfg_data_i
//
// An input frame yields R results (R up to 64); for each result the one shared
// interpolation unit runs a multiply, an add and an output-load step.
// Reset restores channel_count = 2, position_step = 1.0, output_frames = 1 and an empty stream.
// A stalled output holds its result; the next result waits in the datapath until it is taken.
// The input is taken again once the last result of a frame sits in the output register, or once a frame yields none.
module linear_interp_resampler_top import lir_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [CFG_IDX_BITS-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_BITS-1:0] cfg_data_i,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  in_t                      in_data_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output out_t                     out_data_o
);

  ctl_cmd_t   cmd;
  dp_status_t status;
  logic       more_q;

  lir_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .more_q_i   (more_q),
    .cmd_o      (cmd)
  );

  lir_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (in_data_i),
    .out_data_o  (out_data_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .more_q_o    (more_q)
  );

endmodule

// ===== bench/linear_interp_resampler_top_test.sv =====
// Self-checking bench for the linear interpolation resampler: directed table, then random streams.
`timescale 1ns / 1ps

module linear_interp_resampler_top_test import lir_pkg::*;;

  localparam int MAX_CYCLES    = 1_000_000;
  localparam int SETTLE_CYCLES = 250;
  localparam int HOLD_CYCLES   = 600;
  localparam int RAND_FRAMES   = 250;
  localparam int REPORT_LIMIT  = 10;

  localparam logic [CFG_IDX_BITS-1:0] REG_SPARE = 2'd3;
  localparam logic [SAMPLE_BITS-1:0]  SIGN_BIT  = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
  localparam logic [63:0]             ONE_POS   = 64'd1 << FRAC_BITS;

  typedef struct {
    logic                     is_reg;
    logic [CFG_IDX_BITS-1:0]  idx;
    logic [CFG_DATA_BITS-1:0] value;
    in_t                      frame;
    int                       n_typed;
    out_t                     typed;
  } step_row_t;

  logic                     clk_i      = 1'b0;
  logic                     rst_ni     = 1'b0;
  logic                     cfg_we_i   = 1'b0;
  logic [CFG_IDX_BITS-1:0]  cfg_idx_i  = '0;
  logic [CFG_DATA_BITS-1:0] cfg_data_i = '0;
  logic                     in_valid_i = 1'b0;
  logic                     in_stall_o;
  in_t                      in_data_i  = '0;
  logic                     out_valid_o;
  logic                     out_stall_i = 1'b0;
  out_t                     out_data_o;

  // Predictor registers and stream state.
  logic [CHAN_BITS-1:0]   cfg_chan  = 2'd2;
  logic [STEP_BITS-1:0]   cfg_step  = STEP_BITS'(ONE_POS);
  logic [INDEX_BITS-1:0]  cfg_total = 32'd1;
  logic [SAMPLE_BITS-1:0] prev_a;
  logic [SAMPLE_BITS-1:0] prev_b;
  logic                   have_prev;
  logic [INDEX_BITS-1:0]  frame_idx;
  logic [POS_BITS-1:0]    read_pos;
  logic [INDEX_BITS-1:0]  emitted;

  out_t      frame_results[$];
  out_t      owed_frames[$];
  step_row_t script[$];

  int cycle_count     = 0;
  int fail_count      = 0;
  int frames_in       = 0;
  int outputs_seen    = 0;
  int streams         = 0;
  int reg_writes      = 0;
  int send_idle_pct   = 0;
  int recv_stall_pct  = 0;
  int burst_count     = 0;
  int burst_seen      = 0;
  int hold_left       = 0;
  bit sent_since_idle = 1'b0;

  linear_interp_resampler_top DUT (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_data_i,
    .in_valid_i,
    .in_stall_o,
    .in_data_i,
    .out_valid_o,
    .out_stall_i,
    .out_data_o
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > MAX_CYCLES) begin
      $display("timeout after %0d cycles, %0d results still owed", cycle_count,
               owed_frames.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic void note_fail(input string msg);
    if (fail_count < REPORT_LIMIT) $display("ERROR @%0t: %s", $time, msg);
    fail_count++;
  endfunction

  function automatic void clear_stream();
    prev_a    = '0;
    prev_b    = '0;
    have_prev = 1'b0;
    frame_idx = '0;
    read_pos  = '0;
    emitted   = '0;
  endfunction

  // Blend in offset binary, round to nearest with ties upward.
  function automatic logic [SAMPLE_BITS-1:0] blend_sample(input logic [SAMPLE_BITS-1:0] p,
                                                          input logic [SAMPLE_BITS-1:0] c,
                                                          input logic [FRAC_BITS-1:0] f);
    logic [63:0] sum;
    sum = 64'(p ^ SIGN_BIT) * (ONE_POS - 64'(f)) + 64'(c ^ SIGN_BIT) * 64'(f) + (ONE_POS >> 1);
    return sum[FRAC_BITS +: SAMPLE_BITS] ^ SIGN_BIT;
  endfunction

  function automatic void emit_frame(input logic [SAMPLE_BITS-1:0] a,
                                     input logic [SAMPLE_BITS-1:0] b);
    out_t r;
    emitted       = emitted + 1;
    r.out_a       = a;
    r.out_b       = b;
    r.run_last    = 1'b0;
    r.stream_done = (emitted == cfg_total);
    read_pos      = read_pos + POS_BITS'(cfg_step);
    frame_results = {frame_results, r};
  endfunction

  function automatic void predict_outputs(input in_t fr);
    logic                   stereo;
    logic [SAMPLE_BITS-1:0] cur_a;
    logic [SAMPLE_BITS-1:0] cur_b;
    out_t                   tail;
    stereo = (cfg_chan >= 2) && (MAX_CHANNELS >= 2);
    cur_a  = fr.sample_a;
    cur_b  = stereo ? fr.sample_b : '0;
    frame_results.delete();
    if (have_prev) begin
      while (frame_results.size() < MAX_RESULTS && emitted < cfg_total &&
             read_pos[POS_BITS-1:FRAC_BITS] < frame_idx) begin
        emit_frame(blend_sample(prev_a, cur_a, read_pos[FRAC_BITS-1:0]),
                   stereo ? blend_sample(prev_b, cur_b, read_pos[FRAC_BITS-1:0]) : '0);
      end
    end
    if (fr.last_frame) begin
      while (frame_results.size() < MAX_RESULTS && emitted < cfg_total) begin
        emit_frame(cur_a, cur_b);
      end
      if (frame_results.size() > 0) begin
        tail = frame_results.pop_back();
        tail.stream_done = 1'b1;
        frame_results = {frame_results, tail};
      end
    end
    if (frame_results.size() > 0) begin
      tail = frame_results.pop_back();
      tail.run_last = 1'b1;
      frame_results = {frame_results, tail};
    end
    if (fr.last_frame) begin
      clear_stream();
    end else begin
      prev_a    = cur_a;
      prev_b    = cur_b;
      have_prev = 1'b1;
      frame_idx = frame_idx + 1;
    end
  endfunction

  function automatic logic [SAMPLE_BITS-1:0] pick_sample();
    case ($urandom_range(0, 7))
      0: return SIGN_BIT;
      1: return ~SIGN_BIT;
      2: return '0;
      default: return SAMPLE_BITS'($urandom);
    endcase
  endfunction

  function automatic void row_reg(input logic [CFG_IDX_BITS-1:0] idx,
                                  input logic [CFG_DATA_BITS-1:0] value);
    step_row_t r;
    r.is_reg  = 1'b1;
    r.idx     = idx;
    r.value   = value;
    r.frame   = '0;
    r.n_typed = -1;
    r.typed   = '0;
    script    = {script, r};
  endfunction

  function automatic void row_frame(input logic [SAMPLE_BITS-1:0] a,
                                    input logic [SAMPLE_BITS-1:0] b,
                                    input logic last, input int n_typed,
                                    input out_t typed = '0);
    step_row_t r;
    r.is_reg  = 1'b0;
    r.idx     = '0;
    r.value   = '0;
    r.frame   = {a, b, last};
    r.n_typed = n_typed;
    r.typed   = typed;
    script    = {script, r};
  endfunction

  task automatic set_reg(input logic [CFG_IDX_BITS-1:0] idx,
                         input logic [CFG_DATA_BITS-1:0] value);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    case (idx)
      REG_CHANNEL_COUNT: cfg_chan = value[CHAN_BITS-1:0];
      REG_POSITION_STEP: cfg_step = value[STEP_BITS-1:0];
      REG_OUTPUT_FRAMES: cfg_total = value[INDEX_BITS-1:0];
      default: ;
    endcase
    reg_writes++;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic push_frame(input in_t fr, input int n_typed = -1, input out_t typed = '0);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= fr;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predict_outputs(fr);
    if (n_typed < 0) begin
      owed_frames = {owed_frames, frame_results};
    end else if (n_typed > 0) begin
      owed_frames = {owed_frames, typed};
    end
    frames_in++;
    if (fr.last_frame) streams++;
  endtask

  // Drop the request, wait for every owed result, then let the datapath settle.
  task automatic drain_results();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (owed_frames.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  always @(negedge clk_i) begin
    if (burst_seen != burst_count) begin
      burst_seen = burst_count;
      hold_left  = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin : check_outputs
    out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (owed_frames.size() == 0) begin
        note_fail($sformatf("unexpected result a=%h b=%h last=%b done=%b", out_data_o.out_a,
                            out_data_o.out_b, out_data_o.run_last, out_data_o.stream_done));
      end else begin
        want = owed_frames.pop_front();
        outputs_seen++;
        if (out_data_o.out_a !== want.out_a || out_data_o.out_b !== want.out_b ||
            out_data_o.run_last !== want.run_last ||
            out_data_o.stream_done !== want.stream_done) begin
          note_fail($sformatf("expected a=%h b=%h last=%b done=%b, got a=%h b=%h last=%b done=%b",
                              want.out_a, want.out_b, want.run_last, want.stream_done,
                              out_data_o.out_a, out_data_o.out_b, out_data_o.run_last,
                              out_data_o.stream_done));
        end
      end
    end
  end

  initial begin
    in_t                    fr;
    logic [STEP_BITS-1:0]   step;
    logic [INDEX_BITS-1:0]  total;
    logic [CHAN_BITS-1:0]   chan;
    logic [63:0]            span_ticks;
    int                     span;
    int                     len;
    int                     rand_frames;
    bit                     noisy;

    clear_stream();
    rand_frames = 0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    row_reg(REG_SPARE, 32'hA5A5_A5A5);
    row_frame(24'h7FFFFF, 24'h800000, 1'b1, 1, {24'h7FFFFF, 24'h800000, 1'b1, 1'b1});
    row_reg(REG_OUTPUT_FRAMES, 32'd0);
    row_frame(24'h000005, 24'h000006, 1'b1, 0);
    row_reg(REG_OUTPUT_FRAMES, 32'd4);
    row_frame(24'h800000, 24'h7FFFFF, 1'b0, 0);
    row_frame(24'h7FFFFF, 24'h800000, 1'b0, 1, {24'h800000, 24'h7FFFFF, 1'b1, 1'b0});
    row_frame(24'h000000, 24'hFFFFFF, 1'b1, -1);
    row_reg(REG_CHANNEL_COUNT, 32'd1);
    row_reg(REG_POSITION_STEP, 32'd32768);
    row_reg(REG_OUTPUT_FRAMES, 32'hFFFF_FFFF);
    row_frame(24'h01E240, 24'h0003E7, 1'b0, 0);
    row_frame(24'h800000, 24'hFFFFFF, 1'b0, -1);
    row_frame(24'h7FFFFF, 24'h7FFFFF, 1'b0, -1);
    row_frame(24'h123456, 24'h654321, 1'b1, -1);
    row_reg(REG_CHANNEL_COUNT, 32'd3);
    row_reg(REG_POSITION_STEP, 32'd1024);
    row_reg(REG_OUTPUT_FRAMES, 32'd1000);
    row_frame(24'h400000, 24'hC00000, 1'b0, 0);
    row_frame(24'hC00000, 24'h400000, 1'b0, -1);
    row_frame(24'h000001, 24'hFFFFFF, 1'b0, -1);
    row_frame(24'h7FFFFF, 24'h800000, 1'b1, -1);
    row_reg(REG_POSITION_STEP, 32'd100);
    row_reg(REG_CHANNEL_COUNT, 32'd2);
    row_reg(REG_OUTPUT_FRAMES, 32'd200);
    row_frame(24'h111111, 24'hEEEEEE, 1'b0, 0);
    row_frame(24'h222222, 24'hDDDDDD, 1'b0, -1);
    row_frame(24'h333333, 24'hCCCCCC, 1'b0, -1);
    row_frame(24'h444444, 24'hBBBBBB, 1'b1, -1);
    row_reg(REG_CHANNEL_COUNT, 32'd0);
    row_reg(REG_POSITION_STEP, 32'd4194304);
    row_reg(REG_OUTPUT_FRAMES, 32'd2);
    row_frame(24'h0ABCDE, 24'h0FEDCB, 1'b0, 0);
    row_frame(24'hF00000, 24'h0F0000, 1'b0, -1);
    row_frame(24'h0F0000, 24'hF00000, 1'b0, 0);
    row_frame(24'h7FFFFF, 24'h7FFFFF, 1'b1, -1);

    foreach (script[i]) begin
      if (script[i].is_reg) begin
        if (sent_since_idle) begin
          drain_results();
          sent_since_idle = 1'b0;
        end
        set_reg(script[i].idx, script[i].value);
      end else begin
        push_frame(script[i].frame, script[i].n_typed, script[i].typed);
        sent_since_idle = 1'b1;
      end
    end

    for (int phase = 0; rand_frames < RAND_FRAMES; phase++) begin
      drain_results();
      case (phase % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 59; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 59; end
        default: begin send_idle_pct = 27; recv_stall_pct = 27; end
      endcase
      chan = CHAN_BITS'($urandom_range(0, 3));
      case ($urandom_range(0, 9))
        0: step = 23'd1024;
        1: step = 23'd4194304;
        2: step = STEP_BITS'($urandom_range(0, 1023));
        3: step = '1;
        default: step = STEP_BITS'($urandom_range(16384, 262144));
      endcase
      span = $urandom_range(1, 10);
      // Hold the receiver off while the sender keeps offering frames.
      if (phase == 0) begin
        step = 23'd32768;
        burst_count++;
      end
      span_ticks = (64'(span) * 64'(step) + ONE_POS - 1) >> FRAC_BITS;
      span_ticks = span_ticks + 64'($urandom_range(0, 2));
      case ($urandom_range(0, 9))
        0: total = '0;
        1: total = '1;
        2: total = $urandom;
        default: total = (span_ticks > 1) ? INDEX_BITS'(span_ticks - 1) : 32'd1;
      endcase
      set_reg(REG_CHANNEL_COUNT, 32'(chan));
      set_reg(REG_POSITION_STEP, 32'(step));
      set_reg(REG_OUTPUT_FRAMES, total);
      noisy = ($urandom_range(0, 9) == 0);
      repeat ($urandom_range(2, 5)) begin
        len = $urandom_range(1, span + 2);
        for (int k = 0; k < len; k++) begin
          fr.sample_a   = pick_sample();
          fr.sample_b   = pick_sample();
          fr.last_frame = noisy ? 1'($urandom_range(0, 1)) : (k == len - 1);
          push_frame(fr);
          rand_frames++;
        end
      end
    end

    drain_results();
    $display("Drove %0d input frames in %0d streams, checked %0d output frames,",
             frames_in, streams, outputs_seen);
    $display("%0d register writes; covered result cap, lagging and extreme steps,",
             reg_writes);
    $display("mono and stereo, and a %0d-cycle hold-off.", HOLD_CYCLES);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("%0d failures", fail_count);
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/lir_pkg.sv
hw/rtl/lir_ctrl.sv
hw/rtl/lir_datapath.sv
hw/rtl/linear_interp_resampler_top.sv
bench/linear_interp_resampler_top_test.sv
